/* hw/rtl/nrlbd_pkg.sv */
`default_nettype none
package nrlbd_pkg;

    localparam int unsigned CODE_W    = 8;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned PART_W    = 7;
    localparam int unsigned FILL_W    = 3;
    localparam int unsigned TOTAL_W   = 5;
    localparam int unsigned WORD_W    = 23;
    localparam logic [2:0]  LEN_MASK  = 3'b111;
    localparam logic [1:0]  MAX_BYTES = 2'd2;

    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [PART_W-1:0]  part_t;
    typedef logic [FILL_W-1:0]  fill_t;
    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [WORD_W-1:0]  word_t;

    // Run of equal bits from one 4-bit code: bit 3 value, bits 2..0 length minus one
    function automatic byte_t run_bits(input logic [3:0] code);
        byte_t ones;
        ones = 8'hFF >> (LEN_MASK - code[2:0]);
        return code[3] ? ones : 8'h00;
    endfunction

    function automatic logic [3:0] run_len(input logic [3:0] code);
        return {1'b0, code[2:0]} + 4'd1;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/nrlbd_in_if.sv */
`default_nettype none
interface nrlbd_in_if;
    import nrlbd_pkg::*;

    logic  valid;
    logic  ready;
    code_t code_byte;
    logic  final_byte;

    modport source (output valid, output code_byte, output final_byte, input ready);
    modport sink   (input valid, input code_byte, input final_byte, output ready);
endinterface
`default_nettype wire

/* hw/rtl/nrlbd_out_if.sv */
`default_nettype none
interface nrlbd_out_if;
    import nrlbd_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  last_of_item;

    modport source (output valid, output data_byte, output last_of_item, input ready);
    modport sink   (input valid, input data_byte, input last_of_item, output ready);
endinterface
`default_nettype wire

/* hw/rtl/nibble_run_length_bit_decoder.sv */
// An accepted item passes through the input register and then the result register before its first byte leaves.
// Throughput: one item per cycle while each item completes at most one byte and the output is
// not stalled; an item that completes two bytes holds the single output register until both are taken.
// Items completing no byte pass through without using the output side.
// Reset (rst_n, asynchronous, active low) empties both registers, clears the partial byte
// and its fill count, and clears the padding flag.
`default_nettype none
module nibble_run_length_bit_decoder (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_we,
    input  wire                  cfg_data,
    nrlbd_in_if.sink             coded,
    nrlbd_out_if.source          decoded
);
    import nrlbd_pkg::*;

    logic        skip_reg;

    logic        in_valid_reg;
    code_t       in_code_reg;
    logic        in_final_reg;

    part_t       partial_reg, partial_next;
    fill_t       fill_reg, fill_next;

    logic [1:0]  left_reg;
    byte_t       b0_reg;
    byte_t       b1_reg;

    logic        skip_lo;
    logic [3:0]  hi_code, lo_code;
    logic [3:0]  hi_len, lo_len;
    byte_t       hi_bits, lo_bits;
    logic [4:0]  lo_shift;
    total_t      total;
    word_t       word;
    logic [1:0]  cnt;
    logic        out_fire;
    logic        buf_free;
    logic        advance;

    // Expand both runs (the low one skipped on a final byte with padding set) into one word behind the partial bits
    always_comb
    begin
        hi_code  = in_code_reg[7:4];
        lo_code  = in_code_reg[3:0];
        skip_lo  = in_final_reg & skip_reg;
        hi_len   = run_len(hi_code);
        lo_len   = skip_lo ? 4'd0 : run_len(lo_code);
        hi_bits  = run_bits(hi_code);
        lo_bits  = skip_lo ? 8'h00 : run_bits(lo_code);
        lo_shift = {2'b00, fill_reg} + {1'b0, hi_len};
        total    = lo_shift + {1'b0, lo_len};
        word     = {16'b0, partial_reg}
                 | ({15'b0, hi_bits} << fill_reg)
                 | ({15'b0, lo_bits} << lo_shift);
        cnt      = total[4:3];
    end

    always_comb
    begin
        case (cnt)
            2'd0:    partial_next = word[6:0];
            2'd1:    partial_next = word[14:8];
            default: partial_next = word[22:16];
        endcase
        fill_next = total[2:0];
        if (in_final_reg)
        begin
            partial_next = '0;
            fill_next    = '0;
        end
    end

    assign out_fire    = decoded.valid & decoded.ready;
    assign buf_free    = (left_reg == 2'd0) || ((left_reg == 2'd1) && decoded.ready);
    assign advance     = in_valid_reg && ((cnt == 2'd0) || buf_free);
    assign coded.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skip_reg <= 1'b0;
        else if (cfg_we)
            skip_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (coded.ready)
            in_valid_reg <= coded.valid;
    end

    always_ff @(posedge clk)
    begin
        if (coded.ready && coded.valid)
        begin
            in_code_reg  <= coded.code_byte;
            in_final_reg <= coded.final_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            fill_reg    <= '0;
        end
        else if (advance)
        begin
            partial_reg <= partial_next;
            fill_reg    <= fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            left_reg <= 2'd0;
        else if (advance && (cnt != 2'd0))
            left_reg <= cnt;
        else if (out_fire)
            left_reg <= left_reg - 2'd1;
    end

    // Second byte moves to the head once the first is taken
    always_ff @(posedge clk)
    begin
        if (advance && (cnt != 2'd0))
        begin
            b0_reg <= word[7:0];
            b1_reg <= word[15:8];
        end
        else if (out_fire && (left_reg == MAX_BYTES))
            b0_reg <= b1_reg;
    end

    assign decoded.valid        = (left_reg != 2'd0);
    assign decoded.data_byte    = b0_reg;
    assign decoded.last_of_item = (left_reg == 2'd1);

endmodule
`default_nettype wire

/* hw/rtl/nrlbd_checker.sv */
`default_nettype none
module nrlbd_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 in_ready,
    input wire                 out_valid,
    input wire                 out_ready,
    input wire [7:0]           out_data,
    input wire                 out_last
);
    import nrlbd_pkg::*;

    byte_t data_w;
    assign data_w = out_data;

    // A stalled byte holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_w) && $stable(out_last))
        else $error("stalled output byte changed");

    // The second byte of an item is already buffered behind the first
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_valid && out_last)
        else $error("second byte of item did not follow");

    // An empty output side never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // Checked once the clear has certainly landed
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid after reset");

endmodule

bind nibble_run_length_bit_decoder nrlbd_checker u_nrlbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (coded.ready),
    .out_valid (decoded.valid),
    .out_ready (decoded.ready),
    .out_data  (decoded.data_byte),
    .out_last  (decoded.last_of_item)
);
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
module tb;
    import nrlbd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned LONG_HOLD   = 200;
    localparam int unsigned HOLD_AT     = 600;

    typedef struct {
        code_t       code;
        logic        fin;
        int unsigned gap;
    } coded_item_t;

    typedef struct {
        byte_t data_byte;
        logic  last_of_item;
    } decoded_item_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;

    nrlbd_in_if  coded_if ();
    nrlbd_out_if decoded_if ();

    nibble_run_length_bit_decoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .coded    (coded_if.sink),
        .decoded  (decoded_if.source)
    );

    always #5 clk = ~clk;

    coded_item_t   coded_pending[$];
    decoded_item_t expected_bytes[$];

    // predictor state
    logic  pad_flag;
    byte_t fill_bits;
    int    fill_count;

    int unsigned bytes_in;
    int unsigned bytes_checked;
    int unsigned streams_sent;
    int unsigned mismatches;
    int unsigned cycles;
    int unsigned gap_left;
    logic        rx_steady;

    function automatic void decode_expected(input code_t code, input logic fin);
        logic [3:0] run_code;
        byte_t      done [2];
        int         n_done;
        int         k;
        int         i;
        n_done = 0;
        for (k = 0; k < 2; k++) begin
            if (k == 1 && fin && pad_flag)
                break;
            run_code = (k == 0) ? code[7:4] : code[3:0];
            for (i = 0; i <= int'(run_code[2:0]); i++) begin
                fill_bits[fill_count] = run_code[3];
                fill_count++;
                if (fill_count == 8) begin
                    done[n_done] = fill_bits;
                    n_done++;
                    fill_bits  = '0;
                    fill_count = 0;
                end
            end
        end
        // end of stream drops any partly filled byte
        if (fin) begin
            fill_bits  = '0;
            fill_count = 0;
        end
        for (k = 0; k < n_done; k++)
            expected_bytes.push_back('{done[k], logic'(k == n_done - 1)});
    endfunction

    // sender
    always @(posedge clk or negedge rst_n) begin : tx_side
        coded_item_t nxt;
        if (!rst_n) begin
            coded_if.valid      <= 1'b0;
            coded_if.code_byte  <= '0;
            coded_if.final_byte <= 1'b0;
            gap_left            <= 0;
        end
        else if (!(coded_if.valid && !coded_if.ready)) begin
            if (coded_if.valid) begin
                decode_expected(coded_if.code_byte, coded_if.final_byte);
                bytes_in++;
            end
            if (gap_left > 0) begin
                gap_left       <= gap_left - 1;
                coded_if.valid <= 1'b0;
            end
            else if (coded_pending.size() > 0) begin
                nxt = coded_pending.pop_front();
                coded_if.valid      <= 1'b1;
                coded_if.code_byte  <= nxt.code;
                coded_if.final_byte <= nxt.fin;
                gap_left            <= nxt.gap;
            end
            else
                coded_if.valid <= 1'b0;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n) begin : rx_side
        decoded_item_t want;
        int unsigned   stall_left;
        logic          hold_done;
        int unsigned   r;
        if (!rst_n) begin
            decoded_if.ready <= 1'b0;
            stall_left = 0;
            hold_done  = 1'b0;
        end
        else begin
            if (decoded_if.valid && decoded_if.ready) begin
                bytes_checked++;
                if (expected_bytes.size() == 0) begin
                    $error("unexpected item: data_byte %h last_of_item %b",
                           decoded_if.data_byte, decoded_if.last_of_item);
                    mismatches++;
                end
                else begin
                    want = expected_bytes.pop_front();
                    if (decoded_if.data_byte !== want.data_byte) begin
                        $error("data_byte: expected %h, got %h",
                               want.data_byte, decoded_if.data_byte);
                        mismatches++;
                    end
                    if (decoded_if.last_of_item !== want.last_of_item) begin
                        $error("last_of_item: expected %b, got %b",
                               want.last_of_item, decoded_if.last_of_item);
                        mismatches++;
                    end
                end
            end
            // one long hold-off while the sender keeps going, to back the block up
            if (!hold_done && bytes_in >= HOLD_AT) begin
                hold_done  = 1'b1;
                stall_left = LONG_HOLD;
                decoded_if.ready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                decoded_if.ready <= 1'b0;
            end
            else if (rx_steady)
                decoded_if.ready <= 1'b1;
            else begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    decoded_if.ready <= 1'b1;
                else begin
                    decoded_if.ready <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int unsigned pick_gap(input logic gapped);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!gapped || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void add_byte(input code_t code, input logic fin, input logic gapped);
        coded_pending.push_back('{code, fin, pick_gap(gapped)});
    endfunction

    function automatic void add_random(input int unsigned n, input logic gapped);
        int unsigned queued;
        int unsigned len;
        int unsigned j;
        queued = 0;
        while (queued < n) begin
            if ($urandom_range(0, 99) < 85) begin
                // well-formed stream with the final flag on its last byte
                len = $urandom_range(1, 10);
                for (j = 0; j < len; j++)
                    add_byte(code_t'($urandom_range(0, 255)), logic'(j == len - 1), gapped);
                queued += len;
                streams_sent++;
            end
            else begin
                add_byte(code_t'($urandom_range(0, 255)), logic'($urandom_range(0, 1)), gapped);
                queued++;
            end
        end
    endfunction

    task automatic drain();
        while (coded_pending.size() != 0 || coded_if.valid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_pad(input logic v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        pad_flag = v;
    endtask

    initial begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_data            = 1'b0;
        coded_if.valid      = 1'b0;
        coded_if.code_byte  = '0;
        coded_if.final_byte = 1'b0;
        decoded_if.ready    = 1'b0;
        rx_steady           = 1'b0;
        pad_flag            = 1'b0;
        fill_bits           = '0;
        fill_count          = 0;
        bytes_in            = 0;
        bytes_checked       = 0;
        streams_sent        = 0;
        mismatches          = 0;
        cycles              = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed, padding off
        write_pad(1'b0);
        add_byte(8'h00, 1'b0, 1'b1);
        add_byte(8'h77, 1'b0, 1'b1);    // two long zero runs, two bytes
        add_byte(8'hFF, 1'b1, 1'b1);    // sixteen ones, partial dropped
        add_byte(8'hF7, 1'b1, 1'b0);    // byte-aligned: FF then 00
        add_byte(8'h8F, 1'b0, 1'b0);
        add_byte(8'h08, 1'b0, 1'b1);
        add_byte(8'hA3, 1'b1, 1'b0);    // partial byte dropped at end of stream
        add_byte(8'h11, 1'b1, 1'b1);    // no byte completes
        add_byte(8'h7F, 1'b0, 1'b0);
        add_byte(8'hC5, 1'b0, 1'b1);
        add_byte(8'h3E, 1'b1, 1'b0);
        add_byte(8'h80, 1'b1, 1'b1);
        drain();

        // directed, padding on
        write_pad(1'b1);
        add_byte(8'hF7, 1'b1, 1'b1);    // low nibble skipped: one byte only
        add_byte(8'h7F, 1'b0, 1'b0);    // not final, both nibbles used
        add_byte(8'hF0, 1'b1, 1'b0);
        add_byte(8'h3F, 1'b1, 1'b1);    // nothing completes
        add_byte(8'h66, 1'b0, 1'b0);
        add_byte(8'h2A, 1'b1, 1'b1);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h07, 1'b1, 1'b0);
        add_byte(8'h00, 1'b1, 1'b1);
        add_byte(8'hE9, 1'b1, 1'b0);
        drain();

        write_pad(1'b0);
        add_random(390, 1'b1);
        drain();

        write_pad(1'b1);
        add_random(390, 1'b1);
        drain();

        // back-to-back with no stalls on either side
        rx_steady <= 1'b1;
        write_pad(1'b0);
        add_random(380, 1'b0);
        drain();
        rx_steady <= 1'b0;

        write_pad(1'b1);
        add_random(380, 1'b1);
        drain();

        $display("Sent %0d coded bytes (%0d well-formed streams), checked %0d decoded bytes,",
                 bytes_in, streams_sent, bytes_checked);
        $display("with padding on and off, random stalls, a long output hold and a burst.");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/nrlbd_pkg.sv
hw/rtl/nrlbd_in_if.sv
hw/rtl/nrlbd_out_if.sv
hw/rtl/nibble_run_length_bit_decoder.sv
hw/rtl/nrlbd_checker.sv
bench/tb.sv
